// File: hw/rtl/c39_pkg.sv
// ----------------------------------------------------------------------------
// c39_pkg
// Shared types, constants and the symbol tables of the Code 39 run length
// decoder.
// ----------------------------------------------------------------------------
package c39_pkg;

   localparam int SAMPLE_W      = 12;
   localparam int ASCII_W       = 7;
   localparam int SLOT_OUT_W    = 2;
   localparam int GROUP         = 9;
   localparam int TAB_SIZE      = 44;
   localparam int IDX_W         = 6;
   localparam int DEF_MAX_BARS  = 27;
   localparam int DEF_RUN_WIDTH = 16;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [SAMPLE_W-1:0] THRESH_RESET  = 12'd200;
   localparam logic [IDX_W-1:0]    STAR_INDEX    = 6'd43;
   localparam logic [ASCII_W-1:0]  ASCII_UNKNOWN = 7'h3F;
   localparam logic [ASCII_W-1:0]  ASCII_NONE    = 7'h00;

   typedef logic [GROUP-1:0] pattern_type;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_UNMATCHED = 2'd1,
      ST_NO_DIR    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_COUNT,
      BK_CLASSIFY,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic group;
      logic last;
   } job_ctl_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
   } match_type;

   localparam pattern_type PATTERN_TAB [TAB_SIZE] = '{
      9'h034, 9'h121, 9'h061, 9'h160, 9'h031, 9'h130, 9'h070, 9'h025, 9'h124, 9'h064,
      9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C, 9'h04C, 9'h01C,
      9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052, 9'h007, 9'h106, 9'h046, 9'h016,
      9'h181, 9'h0C1, 9'h1C0, 9'h091, 9'h190, 9'h0D0, 9'h085, 9'h184, 9'h0A8, 9'h0A2,
      9'h08A, 9'h02A, 9'h0C4, 9'h094
   };

   localparam logic [ASCII_W-1:0] GLYPH_TAB [TAB_SIZE] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
      7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4A,
      7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h54,
      7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A, 7'h2D, 7'h2E, 7'h24, 7'h2F,
      7'h2B, 7'h25, 7'h20, 7'h2A
   };

   function automatic match_type lookup(pattern_type pat);
      match_type m;
      m = '0;
      for (int k = 0; k < TAB_SIZE; k++) begin
         if (!m.found && PATTERN_TAB[k] == pat) begin
            m.found = 1'b1;
            m.idx   = IDX_W'(k);
         end
      end
      return m;
   endfunction

   function automatic pattern_type flip_pattern(pattern_type pat);
      pattern_type r;
      for (int k = 0; k < GROUP; k++) begin
         r[GROUP-1-k] = pat[k];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/c39_channels.sv
// ----------------------------------------------------------------------------
// c39 channels
// Valid/ready channel bundles for samples in and decoded characters out.
// ----------------------------------------------------------------------------
interface c39_req_if import c39_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface c39_rsp_if import c39_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ASCII_W-1:0]    char_ascii;
   logic [1:0]            status;
   logic                  reversed;
   logic [SLOT_OUT_W-1:0] char_slot;
   logic                  last;

   modport source (output valid, output char_ascii, output status, output reversed,
                   output char_slot, output last, input ready);
   modport sink   (input valid, input char_ascii, input status, input reversed,
                   input char_slot, input last, output ready);
endinterface

// File: hw/rtl/c39_front.sv
// ----------------------------------------------------------------------------
// c39_front
// Sample classifier and run length counter; hands each finished group of
// nine runs, and each end of barcode, to the job queue.
// ----------------------------------------------------------------------------
module c39_front import c39_pkg::*; #(
   parameter int MAX_BARS  = DEF_MAX_BARS,
   parameter int RUN_WIDTH = DEF_RUN_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [SAMPLE_W-1:0]        csr_wr_data,
   c39_req_if.sink                    req_ch,
   output logic                       push_valid,
   output job_ctl_type                push_ctl,
   output logic [GROUP*RUN_WIDTH-1:0] push_runs,
   input  logic                       queue_full
);

   localparam int BAR_W  = $clog2(MAX_BARS + 1);
   localparam int GIDX_W = $clog2(GROUP);
   localparam logic [BAR_W-1:0]     BAR_LIMIT = BAR_W'(MAX_BARS);
   localparam logic [GIDX_W-1:0]    GIDX_LAST = GIDX_W'(GROUP - 1);
   localparam logic [RUN_WIDTH-1:0] RUN_MAX   = '1;
   localparam logic [RUN_WIDTH-1:0] RUN_ONE   = RUN_WIDTH'(1);

   logic [SAMPLE_W-1:0]  thresh_ff, thresh_in;
   logic                 armed_ff, armed_in;
   logic                 last_dark_ff, last_dark_in;
   logic                 gap_wait_ff, gap_wait_in;
   logic [RUN_WIDTH-1:0] run_len_ff, run_len_in;
   logic [BAR_W-1:0]     bar_count_ff, bar_count_in;
   logic [GIDX_W-1:0]    group_idx_ff, group_idx_in;
   logic [RUN_WIDTH-1:0] runs_ff [GROUP];
   logic [RUN_WIDTH-1:0] runs_in [GROUP];

   logic accept;
   logic dark;
   logic run_edge;
   logic do_store;
   logic group_done;
   logic finish;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign dark         = req_ch.sample > thresh_ff;

   always_comb begin
      thresh_in    = csr_wr_en ? csr_wr_data : thresh_ff;
      armed_in     = armed_ff;
      last_dark_in = last_dark_ff;
      gap_wait_in  = gap_wait_ff;
      run_len_in   = run_len_ff;
      bar_count_in = bar_count_ff;
      group_idx_in = group_idx_ff;
      runs_in      = runs_ff;
      run_edge     = 1'b0;
      do_store     = 1'b0;
      group_done   = 1'b0;
      finish       = 1'b0;
      push_valid   = 1'b0;
      push_ctl     = '0;

      if (accept && (armed_ff || dark)) begin
         armed_in = 1'b1;
         run_edge = !gap_wait_ff && (dark != last_dark_ff);
         do_store = run_edge && !(dark && bar_count_ff == '0 && run_len_ff == '0)
                    && run_len_ff != '0 && bar_count_ff < BAR_LIMIT;

         if (run_edge) begin
            run_len_in = RUN_ONE;
         end else if (!gap_wait_ff && run_len_ff != '0 && run_len_ff != RUN_MAX) begin
            run_len_in = run_len_ff + RUN_ONE;
         end

         if (do_store) begin
            for (int k = 0; k < GROUP - 1; k++) begin
               runs_in[k] = runs_ff[k+1];
            end
            runs_in[GROUP-1] = run_len_ff;
            bar_count_in     = bar_count_ff + BAR_W'(1);
            group_done       = (group_idx_ff == GIDX_LAST);
            group_idx_in     = group_done ? '0 : group_idx_ff + GIDX_W'(1);
         end

         if (group_done) begin
            gap_wait_in = 1'b1;
         end
         last_dark_in = dark;

         if (bar_count_in == BAR_LIMIT) begin
            finish       = 1'b1;
            bar_count_in = '0;
            group_idx_in = '0;
            armed_in     = 1'b0;
            gap_wait_in  = 1'b0;
         end

         push_valid     = group_done || finish;
         push_ctl.group = group_done;
         push_ctl.last  = finish;

         // gap ends on the next dark sample
         if (gap_wait_in && dark) begin
            gap_wait_in = 1'b0;
            run_len_in  = RUN_ONE;
         end
      end
   end

   for (genvar g = 0; g < GROUP; g++) begin : g_pack
      assign push_runs[g*RUN_WIDTH +: RUN_WIDTH] = runs_in[g];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= THRESH_RESET;
         armed_ff     <= 1'b0;
         last_dark_ff <= 1'b0;
         gap_wait_ff  <= 1'b0;
         run_len_ff   <= '0;
         bar_count_ff <= '0;
         group_idx_ff <= '0;
      end else begin
         thresh_ff    <= thresh_in;
         armed_ff     <= armed_in;
         last_dark_ff <= last_dark_in;
         gap_wait_ff  <= gap_wait_in;
         run_len_ff   <= run_len_in;
         bar_count_ff <= bar_count_in;
         group_idx_ff <= group_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      runs_ff <= runs_in;
   end

   a_bar_below_limit: assert property (@(posedge clock) disable iff (reset)
      bar_count_ff < BAR_LIMIT)
      else $error("bar count reached its limit without finishing");

   a_gap_only_armed: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> !gap_wait_ff)
      else $error("gap wait set while disarmed");

endmodule

// File: hw/rtl/c39_queue.sv
// ----------------------------------------------------------------------------
// c39_queue
// Small register queue of group jobs between the front and the back.
// ----------------------------------------------------------------------------
module c39_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_DEPTH);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_DEPTH)
      else $error("queue count beyond depth");

endmodule

// File: hw/rtl/c39_back.sv
// ----------------------------------------------------------------------------
// c39_back
// Group classifier: ranks the nine runs of a group against each other, looks
// the pattern up in both directions and drives the registered result channel.
// ----------------------------------------------------------------------------
module c39_back import c39_pkg::*; #(
   parameter int MAX_BARS  = DEF_MAX_BARS,
   parameter int RUN_WIDTH = DEF_RUN_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   input  job_ctl_type                pop_ctl,
   input  logic [GROUP*RUN_WIDTH-1:0] pop_runs,
   output logic                       pop_ready,
   c39_rsp_if.source                  rsp_ch
);

   localparam int SLOT_W = $clog2(MAX_BARS / GROUP + 1);
   localparam int STEP_W = $clog2(GROUP);
   localparam logic [SLOT_W-1:0] SLOT_MAX  = SLOT_W'(MAX_BARS / GROUP);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(GROUP - 1);
   localparam logic [1:0]        CNT_SAT   = 2'd3;

   back_state_type        state_ff, state_in;
   logic [RUN_WIDTH-1:0]  runs_ff [GROUP];
   logic [RUN_WIDTH-1:0]  runs_in [GROUP];
   logic [RUN_WIDTH-1:0]  probe_ff [GROUP];
   logic [RUN_WIDTH-1:0]  probe_in [GROUP];
   logic [1:0]            cnt_ff [GROUP];
   logic [1:0]            cnt_in [GROUP];
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  last_job_ff, last_job_in;
   match_type             fwd_ff, fwd_in;
   match_type             rev_ff, rev_in;
   logic                  dir_known_ff, dir_known_in;
   logic                  dir_rev_ff, dir_rev_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ASCII_W-1:0]    char_ff, char_in;
   status_type            status_ff, status_in;
   logic                  reversed_ff, reversed_in;
   logic [SLOT_OUT_W-1:0] slot_out_ff, slot_out_in;
   logic                  last_out_ff, last_out_in;

   logic [RUN_WIDTH-1:0]  job_runs [GROUP];
   pattern_type           pat;
   logic                  out_free;
   logic                  dir_rev_t;
   logic                  failed;
   match_type             sel;

   for (genvar g = 0; g < GROUP; g++) begin : g_unpack
      assign job_runs[g]        = pop_runs[g*RUN_WIDTH +: RUN_WIDTH];
      // wide when fewer than three runs are strictly longer
      assign pat[GROUP - 1 - g] = (cnt_ff[g] != CNT_SAT);
   end

   assign pop_ready = (state_ff == BK_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.char_ascii = char_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.reversed   = reversed_ff;
   assign rsp_ch.char_slot  = slot_out_ff;
   assign rsp_ch.last       = last_out_ff;

   always_comb begin
      state_in     = state_ff;
      runs_in      = runs_ff;
      probe_in     = probe_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      last_job_in  = last_job_ff;
      fwd_in       = fwd_ff;
      rev_in       = rev_ff;
      dir_known_in = dir_known_ff;
      dir_rev_in   = dir_rev_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      char_in      = char_ff;
      status_in    = status_ff;
      reversed_in  = reversed_ff;
      slot_out_in  = slot_out_ff;
      last_out_in  = last_out_ff;
      dir_rev_t    = dir_rev_ff;
      failed       = 1'b0;
      sel          = fwd_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               if (pop_ctl.group) begin
                  runs_in     = job_runs;
                  probe_in    = job_runs;
                  for (int i = 0; i < GROUP; i++) begin
                     cnt_in[i] = '0;
                  end
                  step_in     = '0;
                  last_job_in = pop_ctl.last;
                  state_in    = BK_COUNT;
               end else if (pop_ctl.last) begin
                  // end of barcode without a full group
                  dir_known_in = 1'b0;
                  slot_in      = '0;
               end
            end
         end
         BK_COUNT: begin
            for (int i = 0; i < GROUP; i++) begin
               if (probe_ff[0] > runs_ff[i] && cnt_ff[i] != CNT_SAT) begin
                  cnt_in[i] = cnt_ff[i] + 2'd1;
               end
            end
            for (int i = 0; i < GROUP - 1; i++) begin
               probe_in[i] = probe_ff[i+1];
            end
            probe_in[GROUP-1] = probe_ff[0];
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = BK_CLASSIFY;
            end
         end
         BK_CLASSIFY: begin
            fwd_in   = lookup(pat);
            rev_in   = lookup(flip_pattern(pat));
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (out_free) begin
               if (!dir_known_ff) begin
                  if (fwd_ff.found && fwd_ff.idx == STAR_INDEX) begin
                     dir_rev_t = 1'b0;
                  end else if (rev_ff.found && rev_ff.idx == STAR_INDEX) begin
                     dir_rev_t = 1'b1;
                  end else begin
                     failed = 1'b1;
                  end
               end
               sel = dir_rev_t ? rev_ff : fwd_ff;
               if (failed) begin
                  char_in     = ASCII_NONE;
                  status_in   = ST_NO_DIR;
                  slot_out_in = '0;
               end else begin
                  char_in     = sel.found ? GLYPH_TAB[sel.idx] : ASCII_UNKNOWN;
                  status_in   = sel.found ? ST_FOUND : ST_UNMATCHED;
                  slot_out_in = SLOT_OUT_W'(slot_ff);
                  if (slot_ff < SLOT_MAX) begin
                     slot_in = slot_ff + SLOT_W'(1);
                  end
               end
               dir_known_in = 1'b1;
               dir_rev_in   = dir_rev_t;
               reversed_in  = dir_rev_t;
               last_out_in  = last_job_ff;
               rsp_valid_in = 1'b1;
               state_in     = BK_IDLE;
               if (last_job_ff) begin
                  dir_known_in = 1'b0;
                  slot_in      = '0;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         dir_known_ff <= 1'b0;
         dir_rev_ff   <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dir_known_ff <= dir_known_in;
         dir_rev_ff   <= dir_rev_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      runs_ff     <= runs_in;
      probe_ff    <= probe_in;
      cnt_ff      <= cnt_in;
      step_ff     <= step_in;
      last_job_ff <= last_job_in;
      fwd_ff      <= fwd_in;
      rev_ff      <= rev_in;
      char_ff     <= char_in;
      status_ff   <= status_in;
      reversed_ff <= reversed_in;
      slot_out_ff <= slot_out_in;
      last_out_ff <= last_out_in;
   end

   a_slot_needs_dir: assert property (@(posedge clock) disable iff (reset)
      slot_ff != '0 |-> dir_known_ff)
      else $error("character slot advanced without a known direction");

   a_count_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_COUNT && step_ff == STEP_LAST |=> state_ff == BK_CLASSIFY)
      else $error("ranking pass did not end after nine steps");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_EMIT && out_free |=> rsp_valid_ff && state_ff == BK_IDLE)
      else $error("emit did not load the result register");

endmodule

// File: hw/rtl/code39_run_length_decoder.sv
// ----------------------------------------------------------------------------
// code39_run_length_decoder
// Code 39 barcode decoder working on a stream of reflectance samples.
// ----------------------------------------------------------------------------
// usage
//   req_ch carries one 12-bit sample per item; a sample above the threshold
//   in csr_wr_data (written with csr_wr_en, reset value 200) is dark.
//   rsp_ch carries one decoded character per group of nine runs, with
//   status, direction, slot and a last flag on the final group.
//   the front takes one sample per cycle while its two-entry job queue has
//   room; every sample waits while the queue is full.
//   a group is ranked in the back in BK_COUNT (one run compared with
//   all nine per cycle), then looked up in BK_CLASSIFY, and BK_EMIT loads
//   the output register once it is free; the back takes a new group only
//   when it has returned to BK_IDLE.
//   a stalled rsp_ch holds the result; the back waits, the queue fills and
//   req_ch.ready drops only when the queue is full.
//   reset is synchronous: the block disarms, clears direction and counters
//   and restores the threshold; it is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module code39_run_length_decoder import c39_pkg::*; #(
   parameter int MAX_BARS  = DEF_MAX_BARS,
   parameter int RUN_WIDTH = DEF_RUN_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [SAMPLE_W-1:0] csr_wr_data,
   c39_req_if.sink             req_ch,
   c39_rsp_if.source           rsp_ch
);

   localparam int RUNS_W = GROUP * RUN_WIDTH;
   localparam int JOB_W  = $bits(job_ctl_type) + RUNS_W;

   logic              push_valid;
   job_ctl_type       push_ctl;
   logic [RUNS_W-1:0] push_runs;
   logic              queue_full;
   logic              pop_valid;
   logic              pop_ready;
   job_ctl_type       pop_ctl;
   logic [RUNS_W-1:0] pop_runs;
   logic [JOB_W-1:0]  push_data;
   logic [JOB_W-1:0]  pop_data;

   assign push_data           = {push_ctl, push_runs};
   assign {pop_ctl, pop_runs} = pop_data;

   c39_front #(
      .MAX_BARS  (MAX_BARS),
      .RUN_WIDTH (RUN_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .push_valid  (push_valid),
      .push_ctl    (push_ctl),
      .push_runs   (push_runs),
      .queue_full  (queue_full)
   );

   c39_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   c39_back #(
      .MAX_BARS  (MAX_BARS),
      .RUN_WIDTH (RUN_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ctl   (pop_ctl),
      .pop_runs  (pop_runs),
      .pop_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule
